/* design/assert_macros.svh */
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clk edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* design/lrnn_pkg.sv */
// Shared types and constants for the linear recurrent step core
`timescale 1ns / 1ps
`default_nettype none
package lrnn_pkg;
	localparam logic [2:0] OP_WREC = 3'd0;
	localparam logic [2:0] OP_WIN  = 3'd1;
	localparam logic [2:0] OP_BIAS = 3'd2;
	localparam logic [2:0] OP_HID  = 3'd3;
	localparam logic [2:0] OP_X    = 3'd4;

	// Classified command handed from front to back
	typedef struct packed {
		logic [2:0]         op;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [15:0] val;
		logic               last;
	} cmd_t;
endpackage
`default_nettype wire

/* design/linear_rnn_recurrence_step_core.sv */
// Top level of the linear recurrent step core
`timescale 1ns / 1ps
`default_nettype none
// Loads weights, bias, hidden and input elements one transaction at a time; the input
// element flagged vector_end runs a step. One multiply-accumulate unit handles
// HIDDEN+INPUT_WIDTH products per row, then the new hidden vector is copied into the
// hidden state; loads pass through a four-entry command queue.
module linear_rnn_recurrence_step_core #(
	parameter int HIDDEN = 16,
	parameter int INPUT_WIDTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [2:0]          operation,
	input  wire [5:0]          row_index,
	input  wire [5:0]          column_index,
	input  wire signed [15:0]  item_value,
	input  wire                vector_end,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [5:0]         hidden_index,
	output logic signed [15:0] hidden_value,
	output logic               final_row
);
	logic cmd_valid, cmd_take;
	lrnn_pkg::cmd_t cmd;

	lrnn_front #(.HIDDEN(HIDDEN), .INPUT_WIDTH(INPUT_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .operation, .row_index, .column_index,
		.item_value, .vector_end, .cmd_valid, .cmd, .cmd_take
	);

	lrnn_back #(.HIDDEN(HIDDEN), .INPUT_WIDTH(INPUT_WIDTH)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take, .out_valid, .out_stall,
		.hidden_index, .hidden_value, .final_row
	);
endmodule
`default_nettype wire

/* design/lrnn_front.sv */
// Front end: accepts transactions, drops invalid ones, queues commands
`timescale 1ns / 1ps
`default_nettype none
module lrnn_front #(
	parameter int HIDDEN = 16,
	parameter int INPUT_WIDTH = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire [2:0]            operation,
	input  wire [5:0]            row_index,
	input  wire [5:0]            column_index,
	input  wire signed [15:0]    item_value,
	input  wire                  vector_end,
	output logic                 cmd_valid,
	output lrnn_pkg::cmd_t       cmd,
	input  wire                  cmd_take
);
	localparam int QD = 4;
	lrnn_pkg::cmd_t q_mem [QD];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic keep, acc;
	lrnn_pkg::cmd_t c;

	always_comb begin
		c.op = operation;
		c.row = row_index;
		c.col = column_index;
		c.val = item_value;
		c.last = vector_end;
		keep = 1'b0;
		case (operation)
			lrnn_pkg::OP_WREC: keep = (32'(row_index) < HIDDEN) && (32'(column_index) < HIDDEN);
			lrnn_pkg::OP_WIN: keep = (32'(row_index) < HIDDEN)
				&& (32'(column_index) < INPUT_WIDTH);
			lrnn_pkg::OP_BIAS, lrnn_pkg::OP_HID: keep = 32'(row_index) < HIDDEN;
			lrnn_pkg::OP_X: keep = (32'(column_index) < INPUT_WIDTH) || vector_end;
			default: keep = 1'b0;
		endcase
	end

	assign in_stall = (cnt_q == 3'(QD));
	assign acc = in_valid && !in_stall && keep;
	assign cmd_valid = (cnt_q != 3'd0);
	assign cmd = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (acc) q_mem[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc) wr_q <= wr_q + 2'd1;
			if (cmd_take) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(acc) - 3'(cmd_take);
		end
	end
endmodule
`default_nettype wire

/* design/lrnn_back.sv */
// Back end: weight stores and the shared multiply-accumulate sequencer
`timescale 1ns / 1ps
`default_nettype none
module lrnn_back #(
	parameter int HIDDEN = 16,
	parameter int INPUT_WIDTH = 16
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	input  lrnn_pkg::cmd_t       cmd,
	output logic                 cmd_take,
	output logic                 out_valid,
	input  wire                  out_stall,
	output logic [5:0]           hidden_index,
	output logic signed [15:0]   hidden_value,
	output logic                 final_row
);
	localparam int HB = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
	localparam int XB = (INPUT_WIDTH > 1) ? $clog2(INPUT_WIDTH) : 1;
	localparam int RB = (HIDDEN * HIDDEN > 1) ? $clog2(HIDDEN * HIDDEN) : 1;
	localparam int IB = (HIDDEN * INPUT_WIDTH > 1) ? $clog2(HIDDEN * INPUT_WIDTH) : 1;
	localparam int KN = HIDDEN + INPUT_WIDTH;
	localparam int KB = $clog2(KN + 1);
	localparam logic [1:0] ST_IDLE = 2'd0, ST_MAC = 2'd1, ST_ACC = 2'd2, ST_OUT = 2'd3;

	logic signed [15:0] wrec_mem [HIDDEN*HIDDEN];
	logic signed [15:0] win_mem [HIDDEN*INPUT_WIDTH];
	logic signed [15:0] bias_mem [HIDDEN];
	logic signed [15:0] nxt_mem [HIDDEN];
	logic signed [15:0] h_q [HIDDEN];
	logic signed [15:0] x_q [INPUT_WIDTH];

	logic [1:0] st_q;
	logic [HB-1:0] r_q, cp_q;
	logic [KB-1:0] k_q;
	logic copy_q;
	logic signed [15:0] wa_s1, va_s1, bias_s1;
	logic pv_s1, pv_s2, pv_s3;
	logic signed [31:0] prod_s2;
	logic signed [47:0] acc_q;
	logic signed [47:0] sh;
	logic signed [15:0] sat;
	logic fire;
	logic [RB-1:0] wr_rec_a, rd_rec_a;
	logic [IB-1:0] wr_in_a, rd_in_a;

	assign cmd_take = cmd_valid && (st_q == ST_IDLE) && !copy_q;
	assign fire = cmd_take && cmd.op == lrnn_pkg::OP_X && cmd.last;

	assign wr_rec_a = RB'(32'(cmd.row) * HIDDEN + 32'(cmd.col));
	assign wr_in_a = IB'(32'(cmd.row) * INPUT_WIDTH + 32'(cmd.col));
	assign rd_rec_a = RB'(32'(r_q) * HIDDEN + 32'(k_q));
	assign rd_in_a = IB'(32'(r_q) * INPUT_WIDTH + 32'(k_q) - HIDDEN);

	// stores
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			case (cmd.op)
				lrnn_pkg::OP_WREC: wrec_mem[wr_rec_a] <= cmd.val;
				lrnn_pkg::OP_WIN: win_mem[wr_in_a] <= cmd.val;
				lrnn_pkg::OP_BIAS: bias_mem[HB'(cmd.row)] <= cmd.val;
				lrnn_pkg::OP_X: if (32'(cmd.col) < INPUT_WIDTH) x_q[XB'(cmd.col)] <= cmd.val;
				default: ;
			endcase
		end
	end

	// operand fetch stage with registered reads, then the registered product
	always_ff @(posedge clk) begin
		if (32'(k_q) < HIDDEN) begin
			wa_s1 <= wrec_mem[rd_rec_a];
			va_s1 <= h_q[HB'(k_q)];
		end else begin
			wa_s1 <= win_mem[rd_in_a];
			va_s1 <= x_q[XB'(32'(k_q) - HIDDEN)];
		end
		bias_s1 <= bias_mem[r_q];
		prod_s2 <= wa_s1 * va_s1;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_ACC && !pv_s2) nxt_mem[r_q] <= sat;
	end

	always_comb begin
		sh = acc_q >>> 8;
		if (sh > 48'sd32767) sat = 16'sh7fff;
		else if (sh < -48'sd32768) sat = -16'sh8000;
		else sat = sh[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			r_q <= '0;
			k_q <= '0;
			cp_q <= '0;
			copy_q <= 1'b0;
			pv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
			pv_s3 <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < HIDDEN; i++) h_q[i] <= '0;
		end else begin
			pv_s1 <= (st_q == ST_MAC);
			pv_s2 <= pv_s1;
			pv_s3 <= pv_s2;
			if (cmd_take && cmd.op == lrnn_pkg::OP_HID) h_q[HB'(cmd.row)] <= cmd.val;
			case (st_q)
				ST_IDLE: begin
					if (fire) begin
						st_q <= ST_MAC;
						r_q <= '0;
						k_q <= '0;
					end
				end
				ST_MAC: begin
					if (k_q == KB'(KN - 1)) st_q <= ST_ACC;
					else k_q <= k_q + KB'(1);
				end
				ST_ACC: begin
					if (!pv_s1 && !pv_s2) st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						hidden_index <= 6'(r_q);
						hidden_value <= nxt_mem[r_q];
						final_row <= (32'(r_q) == HIDDEN - 1);
						if (32'(r_q) == HIDDEN - 1) begin
							st_q <= ST_IDLE;
							copy_q <= 1'b1;
							cp_q <= '0;
						end else begin
							r_q <= r_q + HB'(1);
							k_q <= '0;
							st_q <= ST_MAC;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (out_valid && !out_stall && !(st_q == ST_OUT)) out_valid <= 1'b0;
			if (copy_q) begin
				h_q[cp_q] <= nxt_mem[cp_q];
				if (32'(cp_q) == HIDDEN - 1) copy_q <= 1'b0;
				else cp_q <= cp_q + HB'(1);
			end
		end
	end

	// accumulator: bias seeds it when the first product lands
	always_ff @(posedge clk) begin
		if (pv_s2 && !pv_s3) acc_q <= 48'(bias_s1) * 48'sd256 + 48'(prod_s2);
		else if (pv_s2) acc_q <= acc_q + 48'(prod_s2);
	end
endmodule
`default_nettype wire

/* design/lrnn_checker.sv */
// Port-level checker for the linear recurrent step core
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lrnn_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_stall,
	input wire [5:0] hidden_index,
	input wire       final_row
);
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(hidden_index), "stalled result changed")
	`CHK_NEXT(a_seq, clk, arst_n, out_valid && !out_stall && !final_row, !out_valid || hidden_index == $past(hidden_index) + 6'd1, "row order broken")
	`CHK_NEXT(a_first, clk, arst_n, out_valid && !out_stall && final_row, !out_valid || hidden_index == 6'd0, "step not from row zero")
endmodule
bind linear_rnn_recurrence_step_core lrnn_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .hidden_index, .final_row
);
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the linear recurrent step core
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	localparam int NROW = 16;
	localparam int NCOL = 16;

	typedef struct {
		logic [2:0]         op;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [15:0] val;
		logic               last;
		int                 chk_row;  // -1: no hand-typed result for this row
		logic signed [15:0] chk_val;
	} stim_t;

	typedef struct {
		logic [5:0]         idx;
		logic signed [15:0] val;
		logic               fin;
	} hid_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] operation = '0;
	logic [5:0] row_index = '0;
	logic [5:0] column_index = '0;
	logic signed [15:0] item_value = '0;
	logic vector_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [5:0] hidden_index;
	logic signed [15:0] hidden_value;
	logic final_row;

	logic signed [15:0] w_rec [NROW*NROW];
	logic signed [15:0] w_in [NROW*NCOL];
	logic signed [15:0] bias [NROW];
	logic signed [15:0] h_cur [NROW];
	logic signed [15:0] x_cur [NCOL];
	hid_t hidden_q[$];
	stim_t directed[$];
	int mismatches = 0;
	int steps_run = 0;
	int rows_seen = 0;
	bit calm = 1'b0;
	bit src_done = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	linear_rnn_recurrence_step_core #(.HIDDEN(NROW), .INPUT_WIDTH(NCOL)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .row_index(row_index), .column_index(column_index),
		.item_value(item_value), .vector_end(vector_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.hidden_index(hidden_index), .hidden_value(hidden_value), .final_row(final_row)
	);

	function automatic logic signed [15:0] q88_sat(longint acc);
		longint q;
		q = acc >>> 8;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return 16'(q);
	endfunction

	// update state and queue the new hidden vector on a step
	function automatic void predict_hidden(stim_t s);
		logic signed [15:0] nxt [NROW];
		longint acc;
		case (s.op)
			lrnn_pkg::OP_WREC:
				if (s.row < NROW && s.col < NROW) w_rec[s.row*NROW + s.col] = s.val;
			lrnn_pkg::OP_WIN:
				if (s.row < NROW && s.col < NCOL) w_in[s.row*NCOL + s.col] = s.val;
			lrnn_pkg::OP_BIAS: if (s.row < NROW) bias[s.row] = s.val;
			lrnn_pkg::OP_HID:  if (s.row < NROW) h_cur[s.row] = s.val;
			lrnn_pkg::OP_X: begin
				if (s.col < NCOL) x_cur[s.col] = s.val;
				if (s.last) begin
					for (int r = 0; r < NROW; r++) begin
						acc = longint'(bias[r]) * 256;
						for (int k = 0; k < NROW; k++)
							acc += longint'(w_rec[r*NROW + k]) * longint'(h_cur[k]);
						for (int k = 0; k < NCOL; k++)
							acc += longint'(w_in[r*NCOL + k]) * longint'(x_cur[k]);
						nxt[r] = q88_sat(acc);
					end
					for (int r = 0; r < NROW; r++) begin
						if (s.chk_row == r && nxt[r] != s.chk_val) begin
							mismatches++;
							if (mismatches <= 10)
								$display("table row %0d: model gives %0d, typed %0d",
									r, nxt[r], s.chk_val);
						end
						hidden_q.push_back('{idx: 6'(r), val: nxt[r], fin: r == NROW-1});
						h_cur[r] = nxt[r];
					end
					steps_run++;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(stim_t s);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= s.op;
		row_index <= s.row;
		column_index <= s.col;
		item_value <= s.val;
		vector_end <= s.last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_hidden(s);
	endtask

	function automatic stim_t mk(logic [2:0] op, int row, int col, int val, bit last);
		return '{op: op, row: 6'(row), col: 6'(col), val: 16'(val), last: last,
			chk_row: -1, chk_val: '0};
	endfunction

	// load every weight and bias so no step reads an unwritten entry
	task automatic fill_all(bit big);
		for (int r = 0; r < NROW; r++) begin
			for (int k = 0; k < NROW; k++)
				send_item(mk(lrnn_pkg::OP_WREC, r, k,
					big ? $urandom : $urandom_range(0, 96) - 48, 0));
			for (int k = 0; k < NCOL; k++)
				send_item(mk(lrnn_pkg::OP_WIN, r, k,
					big ? $urandom : $urandom_range(0, 96) - 48, 0));
			send_item(mk(lrnn_pkg::OP_BIAS, r, 0, $urandom, 0));
		end
	endtask

	task automatic send_vector(int n);
		for (int i = 0; i < n; i++)
			send_item(mk(lrnn_pkg::OP_X, 0, $urandom_range(0, NCOL-1), $urandom, i == n-1));
	endtask

	initial begin
		stim_t s;
		for (int i = 0; i < NROW*NROW; i++) w_rec[i] = '0;
		for (int i = 0; i < NROW*NCOL; i++) w_in[i] = '0;
		for (int i = 0; i < NROW; i++) begin
			bias[i] = '0;
			h_cur[i] = '0;
		end
		for (int i = 0; i < NCOL; i++) x_cur[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero everything, then directed corners
		for (int r = 0; r < NROW; r++) begin
			for (int k = 0; k < NROW; k++) send_item(mk(lrnn_pkg::OP_WREC, r, k, 0, 0));
			for (int k = 0; k < NCOL; k++) send_item(mk(lrnn_pkg::OP_WIN, r, k, 0, 0));
			send_item(mk(lrnn_pkg::OP_BIAS, r, 0, 0, 0));
		end
		for (int k = 0; k < NCOL; k++) send_item(mk(lrnn_pkg::OP_X, 0, k, 0, 0));

		directed.push_back(mk(lrnn_pkg::OP_BIAS, 0, 0, 16'sh7fff, 1));  // end flag ignored
		directed.push_back(mk(lrnn_pkg::OP_BIAS, 1, 0, 16'sh8000, 0));
		directed.push_back(mk(lrnn_pkg::OP_BIAS, 63, 0, 16'sh1234, 0)); // row out of range
		directed.push_back(mk(lrnn_pkg::OP_WREC, 2, 63, 16'sh0100, 0)); // column out of range
		directed.push_back(mk(lrnn_pkg::OP_WIN, 63, 2, 16'sh0100, 0));
		directed.push_back(mk(3'd7, 5, 5, 16'shffff, 1));       // unknown op
		directed.push_back(mk(3'd5, 0, 0, 16'sh7fff, 1));
		s = mk(lrnn_pkg::OP_X, 0, 63, 16'sh7fff, 1);            // step with dropped element
		s.chk_row = 0;
		s.chk_val = 16'sh7fff;
		directed.push_back(s);
		directed.push_back(mk(lrnn_pkg::OP_WREC, 0, 0, 16'sh8000, 0));
		directed.push_back(mk(lrnn_pkg::OP_WIN, 0, 15, 16'sh8000, 0));
		directed.push_back(mk(lrnn_pkg::OP_HID, 3, 0, 16'sh8000, 0));  // new sequence, one row
		directed.push_back(mk(lrnn_pkg::OP_X, 0, 15, 16'sh7fff, 0));
		s = mk(lrnn_pkg::OP_X, 0, 0, 16'sh8000, 1);             // huge products saturate
		s.chk_row = 0;
		s.chk_val = 16'sh8000;
		directed.push_back(s);
		directed.push_back(mk(lrnn_pkg::OP_WREC, 15, 15, 16'shffff, 0));
		directed.push_back(mk(lrnn_pkg::OP_X, 0, 0, 16'sh0001, 1));
		foreach (directed[i]) send_item(directed[i]);

		// random: loads at random, broken sequences, then random-content steps
		fill_all(0);
		for (int i = 0; i < 120; i++) begin
			if (i == 100) calm = 1'b1;
			case ($urandom_range(0, 9))
				0: send_item(mk(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
					$urandom)); // noise
				1: send_item(mk(3'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
					$urandom));
				2: send_item(mk(lrnn_pkg::OP_HID, $urandom_range(0, NROW-1), 0, $urandom, 0));
				3: send_item(mk(lrnn_pkg::OP_X, 0, $urandom, $urandom, $urandom));
				default: send_vector($urandom_range(1, 4));
			endcase
		end
		in_valid <= 1'b0;
		src_done = 1'b1;
	end

	// result side: random stall bursts, compare against expected hidden rows
	initial begin
		hid_t e;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			if (out_valid && !out_stall) begin
				rows_seen++;
				if (hidden_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected row %0d value %0d", hidden_index, hidden_value);
				end else begin
					e = hidden_q.pop_front();
					if (hidden_index !== e.idx || hidden_value !== e.val ||
						final_row !== e.fin) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp idx %0d val %0d fin %0b, got %0d %0d %0b",
								e.idx, e.val, e.fin, hidden_index, hidden_value, final_row);
					end
				end
			end
		end
	end

	initial begin
		wait (src_done);
		while (hidden_q.size() != 0) @(posedge clk);
		repeat (800) @(posedge clk);
		$display("Ran %0d recurrent steps, %0d hidden rows checked, %0d mismatches.",
			steps_run, rows_seen, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#100ms;
		$display("Timeout waiting for hidden rows.");
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire
